// File: rtl/core/parallel_printer_port_handshake_macros.svh
// Assertion macros shared by the printer-port handshake RTL.
// Each macro expects i_clk and i_rst_n in scope of the module that uses it.
`ifndef PARALLEL_PRINTER_PORT_HANDSHAKE_MACROS_SVH
`define PARALLEL_PRINTER_PORT_HANDSHAKE_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define PPPH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define PPPH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ppph_pkg.sv
// Package for the printer-port handshake: codes, result types, reset values
// and status formatting. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppph_pkg;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_INIT   = 2'd1,
        REQ_STATUS = 2'd2,
        REQ_TICK   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_CTRL    = 2'd1,
        KIND_STATUS  = 2'd2,
        KIND_IGNORED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WRITE = 2'd1,
        PH_INIT  = 2'd2
    } t_phase;

    localparam logic [1:0] CFG_PORT_PRESENT = 2'd0;
    localparam logic [1:0] CFG_POLL_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_INIT_DELAY   = 2'd2;

    localparam logic [3:0]  RST_PORT_PRESENT = 4'd1;
    localparam logic [15:0] RST_POLL_LIMIT   = 16'd32000;
    localparam logic [15:0] RST_INIT_DELAY   = 16'd1500;

    localparam logic [7:0] CTRL_STROBE_ON = 8'h0D;
    localparam logic [7:0] CTRL_IDLE      = 8'h0C;
    localparam logic [7:0] CTRL_INIT      = 8'h08;

    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  port;
        logic [7:0]  value;
    } t_result;

    typedef struct packed {
        logic [2:0]                    count;
        t_result [MAX_RESULTS-1:0]     res;
    } t_bundle;

    function automatic logic [7:0] fmt_status(input logic [7:0] s);
        return (s & 8'hF8) ^ 8'h48;
    endfunction

    function automatic logic [7:0] fmt_timeout(input logic [7:0] s);
        return ((s & 8'hF8) | 8'h01) ^ 8'h48;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ppph_engine.sv
// Handshake state machine: turns one accepted item into a bundle of up to
// four results and advances phase, poll/wait count and active port. Uses ppph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppph_engine
    import ppph_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire t_req        i_req,
    input  wire logic [2:0]  i_port,
    input  wire logic [7:0]  i_data,
    input  wire logic [7:0]  i_sample,
    input  wire logic [3:0]  i_port_present,
    input  wire logic [15:0] i_poll_limit,
    input  wire logic [15:0] i_init_delay,
    output t_bundle          o_bundle
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_wait_count, n_wait_count;
    logic [1:0]  r_active_port, n_active_port;

    logic [15:0] w_limit;
    logic [15:0] w_delay;
    logic [15:0] w_poll_next;
    logic [15:0] w_init_next;
    logic        w_ready_bit;
    logic        w_port_ok;
    t_result     w_ignored;

    assign w_limit     = (i_poll_limit == '0) ? 16'd1 : i_poll_limit;
    assign w_delay     = (i_init_delay == '0) ? 16'd1 : i_init_delay;
    assign w_poll_next = r_wait_count + 16'd1;
    assign w_init_next = (r_wait_count != '0) ? r_wait_count - 16'd1 : '0;
    assign w_ready_bit = i_sample[7];
    assign w_port_ok   = !i_port[2] && i_port_present[i_port[1:0]];
    assign w_ignored   = '{kind: KIND_IGNORED, port: i_port[1:0], value: 8'h00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_wait_count  <= '0;
            r_active_port <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_wait_count  <= n_wait_count;
            r_active_port <= n_active_port;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_wait_count  = r_wait_count;
        n_active_port = r_active_port;
        o_bundle      = '0;
        unique case (r_phase)
            PH_WRITE: begin
                if (i_req == REQ_TICK) begin
                    if (w_ready_bit) begin
                        // strobe pulse then status reply
                        o_bundle.count  = 3'd3;
                        o_bundle.res[0] = '{KIND_CTRL, r_active_port, CTRL_STROBE_ON};
                        o_bundle.res[1] = '{KIND_CTRL, r_active_port, CTRL_IDLE};
                        o_bundle.res[2] = '{KIND_STATUS, r_active_port,
                                            fmt_status(i_sample)};
                        n_phase      = PH_IDLE;
                        n_wait_count = '0;
                    end else if (w_poll_next >= w_limit) begin
                        o_bundle.count  = 3'd1;
                        o_bundle.res[0] = '{KIND_STATUS, r_active_port,
                                            fmt_timeout(i_sample)};
                        n_phase      = PH_IDLE;
                        n_wait_count = '0;
                    end else begin
                        n_wait_count = w_poll_next;
                    end
                end else begin
                    o_bundle.count  = 3'd1;
                    o_bundle.res[0] = w_ignored;
                end
            end
            PH_INIT: begin
                if (i_req == REQ_TICK) begin
                    n_wait_count = w_init_next;
                    if (w_init_next == '0) begin
                        o_bundle.count  = 3'd2;
                        o_bundle.res[0] = '{KIND_CTRL, r_active_port, CTRL_IDLE};
                        o_bundle.res[1] = '{KIND_STATUS, r_active_port,
                                            fmt_status(i_sample)};
                        n_phase = PH_IDLE;
                    end
                end else begin
                    o_bundle.count  = 3'd1;
                    o_bundle.res[0] = w_ignored;
                end
            end
            default: begin
                // idle, and the unused phase code behaves as idle
                if (i_req == REQ_TICK) begin
                    o_bundle.count = 3'd0;
                end else if (!w_port_ok) begin
                    o_bundle.count  = 3'd1;
                    o_bundle.res[0] = w_ignored;
                end else begin
                    n_active_port = i_port[1:0];
                    unique case (i_req)
                        REQ_WRITE: begin
                            // the request's own sample is the first poll
                            o_bundle.res[0] = '{KIND_DATA, i_port[1:0], i_data};
                            if (w_ready_bit) begin
                                o_bundle.count  = 3'd4;
                                o_bundle.res[1] = '{KIND_CTRL, i_port[1:0],
                                                    CTRL_STROBE_ON};
                                o_bundle.res[2] = '{KIND_CTRL, i_port[1:0], CTRL_IDLE};
                                o_bundle.res[3] = '{KIND_STATUS, i_port[1:0],
                                                    fmt_status(i_sample)};
                                n_phase      = PH_IDLE;
                                n_wait_count = '0;
                            end else if (16'd1 >= w_limit) begin
                                o_bundle.count  = 3'd2;
                                o_bundle.res[1] = '{KIND_STATUS, i_port[1:0],
                                                    fmt_timeout(i_sample)};
                                n_phase      = PH_IDLE;
                                n_wait_count = '0;
                            end else begin
                                o_bundle.count = 3'd1;
                                n_phase        = PH_WRITE;
                                n_wait_count   = 16'd1;
                            end
                        end
                        REQ_INIT: begin
                            o_bundle.count  = 3'd1;
                            o_bundle.res[0] = '{KIND_CTRL, i_port[1:0], CTRL_INIT};
                            n_phase         = PH_INIT;
                            n_wait_count    = w_delay;
                        end
                        default: begin
                            o_bundle.count  = 3'd1;
                            o_bundle.res[0] = '{KIND_STATUS, i_port[1:0],
                                                fmt_status(i_sample)};
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/parallel_printer_port_handshake.sv
// Printer-port handshake controller, top level: stream ports, configuration
// registers and result buffer. Uses ppph_pkg, ppph_engine and the macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "parallel_printer_port_handshake_macros.svh"

// One input transaction is taken per clock whenever the result buffer is empty
// or its last result leaves in the same cycle; the item is decoded in a single
// combinational pass into one to four results (or none for a quiet tick) and
// those are loaded into the result buffer at the same edge. Results then leave
// one per cycle while m_axis_tready is high, the last one of an item flagged by
// tlast; items with zero or one result stream at one per clock under that same
// condition, while more results hold the next item off until the last leaves. The
// result buffer drain alone sets the rate. Configuration writes are always taken
// (o_cfg_ready is tied high) and should only be issued while idle.
module parallel_printer_port_handshake
    import ppph_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // port_index[2:0], data_byte[10:3],
                                             // status_sample[18:11], zero pad
    input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // out_port[1:0], out_value[9:2], zero pad
    output logic [1:0]       m_axis_tuser,   // out_kind[1:0]
    output logic             m_axis_tlast,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [3:0]  r_port_present;
    logic [15:0] r_poll_limit;
    logic [15:0] r_init_delay;

    // result buffer: one decoded bundle, drained one result per transaction
    t_result [MAX_RESULTS-1:0] r_res;
    logic [2:0]                r_cnt;
    logic [1:0]                r_idx;

    t_bundle w_bundle;
    logic    w_s_accept;
    logic    w_m_accept;
    logic    w_last;
    t_result w_head;

    assign o_cfg_ready = 1'b1;

    // Hold configuration; writes beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_present <= RST_PORT_PRESENT;
            r_poll_limit   <= RST_POLL_LIMIT;
            r_init_delay   <= RST_INIT_DELAY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PORT_PRESENT: r_port_present <= i_cfg_data[3:0];
                CFG_POLL_LIMIT:   r_poll_limit   <= i_cfg_data;
                CFG_INIT_DELAY:   r_init_delay   <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    ppph_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_s_accept),
        .i_req          (t_req'(s_axis_tuser)),
        .i_port         (s_axis_tdata[2:0]),
        .i_data         (s_axis_tdata[10:3]),
        .i_sample       (s_axis_tdata[18:11]),
        .i_port_present (r_port_present),
        .i_poll_limit   (r_poll_limit),
        .i_init_delay   (r_init_delay),
        .o_bundle       (w_bundle)
    );

    // Head of the buffer is the current result; tlast marks its final entry.
    assign w_head        = r_res[r_idx];
    assign w_last        = (({1'b0, r_idx} + 3'd1) == r_cnt);
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {6'd0, w_head.value, w_head.port};
    assign m_axis_tuser  = w_head.kind;
    assign m_axis_tlast  = w_last;

    assign w_m_accept    = m_axis_tvalid && m_axis_tready;
    // Take a new item when the buffer is empty or is emptied this cycle.
    assign s_axis_tready = (r_cnt == '0) || (m_axis_tready && w_last);
    assign w_s_accept    = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (w_s_accept) begin
            r_cnt <= w_bundle.count;
            r_idx <= '0;
        end else if (w_m_accept) begin
            if (w_last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_res <= w_bundle.res;
        end
    end

    // An item may only enter over a pending result when that result closes its bundle.
    `PPPH_ASSERT_NOW(a_enter_on_drain, s_axis_tready && m_axis_tvalid,
        m_axis_tlast && m_axis_tready, "input taken while results still pending")
    // A bundle never holds more results than an item can produce.
    `PPPH_ASSERT_NOW(a_count_bound, 1'b1, r_cnt <= 3'd4, "result count out of range")
    // A result that is not the last one is always followed by another.
    `PPPH_ASSERT_NEXT(a_bundle_continues, w_m_accept && !m_axis_tlast,
        m_axis_tvalid, "bundle ended before its last result")
    // After the last result with no new item, the output falls idle.
    `PPPH_ASSERT_NEXT(a_idle_after_last, w_m_accept && m_axis_tlast && !w_s_accept,
        !m_axis_tvalid, "result shown after bundle was drained")

endmodule

`default_nettype wire
